@@ rtl/core/tun_pkg.sv @@
// Package for the triangle unit normal block: constants and widths.
package tun_pkg;
    localparam int CoordWidth     = 24;
    localparam int NormalFracBits = 14;
    localparam int OutWidth       = 16;
endpackage

@@ rtl/core/tun_divider.sv @@
// Pipelined restoring divider: one quotient bit per stage, stall-aware.
module tun_divider #(
    parameter int NumWidth = 46,
    parameter int DenWidth = 32
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [NumWidth-1:0] i_num,
    input  logic [DenWidth-1:0] i_den,
    output logic [NumWidth-1:0] o_quo
);
    // Partial remainders and quotients travel one stage per enabled cycle.
    logic [DenWidth-1:0] r_rem [NumWidth];
    logic [NumWidth-1:0] r_num [NumWidth];
    logic [DenWidth-1:0] r_den [NumWidth];

    for (genvar g = 0; g < NumWidth; g++) begin : g_stage
        logic [DenWidth-1:0] in_rem;
        logic [NumWidth-1:0] in_num;
        logic [DenWidth-1:0] in_den;
        logic [DenWidth+1:0] n_try;
        logic [DenWidth:0]   n_sh;
        // First stage starts from a zero remainder.
        if (g == 0) begin : g_in
            assign in_rem = '0;
            assign in_num = i_num;
            assign in_den = i_den;
        end else begin : g_in
            assign in_rem = r_rem[g-1];
            assign in_num = r_num[g-1];
            assign in_den = r_den[g-1];
        end
        assign n_sh  = {in_rem, in_num[NumWidth-1]};
        assign n_try = {1'b0, n_sh} - {2'b00, in_den};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_try[DenWidth+1] ? n_sh[DenWidth-1:0] : n_try[DenWidth-1:0];
                r_num[g] <= {in_num[NumWidth-2:0], ~n_try[DenWidth+1]};
                r_den[g] <= in_den;
            end
        end
    end

    assign o_quo = r_num[NumWidth-1];
endmodule

@@ rtl/core/triangle_unit_normal_core.sv @@
// Top level of the triangle unit normal block.
// Usage:
//  Slave channel s_axis_* takes one triangle per word (nine packed
//  coordinates, ax in the low bits). Master channel m_axis_* gives the
//  unit normal x,y,z in tdata and the degenerate flag in tuser.
//  The whole datapath is one pipeline: edge subtract, products, cross
//  sums, magnitude, shift count, normalizing shift, squares and sum
//  (8 stages), a 32-stage square root (one result bit per stage), the
//  dividend setup (1 stage), a divider with one quotient bit per stage
//  (31 + NORMAL_FRAC_BITS + 1 = 46 stages) and the output register.
//  That is 88 register stages at default parameters. Throughput is one
//  triangle per cycle while the receiver does not stall. The pipeline
//  advances whenever the output stage is empty or taken, so a stalled
//  receiver freezes every stage and nothing is lost; ready then falls.
//  Reset clears the valid bits only.
module triangle_unit_normal_core #(
    parameter int COORD_WIDTH      = tun_pkg::CoordWidth,
    parameter int NORMAL_FRAC_BITS = tun_pkg::NormalFracBits
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // normal_x, normal_y, normal_z
    output logic [47:0]               m_axis_tdata,
    // degenerate
    output logic                      m_axis_tuser
);
    import tun_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = CW + 1;           // edge width
    localparam int PW  = 2 * DW;           // product width
    localparam int NW  = PW + 1;           // cross component (signed)
    localparam int MW  = NW;               // magnitude width
    localparam int QW  = 31 + NORMAL_FRAC_BITS + 1;
    localparam int NSQ = 32;               // sqrt result bits, one per stage
    localparam int DEPTH = 8 + NSQ + 1 + QW + 1;

    // Pipeline advance and per-stage valid bits.
    logic en;
    logic [DEPTH-1:0] r_vld;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], s_axis_tvalid};
        end
    end
    assign m_axis_tvalid = r_vld[DEPTH-1];

    // Stage 1: edge vectors.
    logic signed [CW-1:0] c [9];
    for (genvar g = 0; g < 9; g++) begin : g_unpack
        assign c[g] = s_axis_tdata[g*CW +: CW];
    end
    logic signed [DW-1:0] r_u [3], r_v [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_u[k] <= DW'(c[3+k]) - DW'(c[k]);
                r_v[k] <= DW'(c[6+k]) - DW'(c[k]);
            end
        end
    end

    // Stage 2: the six products (25x25 each).
    logic signed [PW-1:0] r_p [6];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0] <= r_u[1] * r_v[2];
            r_p[1] <= r_u[2] * r_v[1];
            r_p[2] <= r_u[2] * r_v[0];
            r_p[3] <= r_u[0] * r_v[2];
            r_p[4] <= r_u[0] * r_v[1];
            r_p[5] <= r_u[1] * r_v[0];
        end
    end

    // Stage 3: cross product components.
    logic signed [NW-1:0] r_n [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_n[k] <= NW'(r_p[2*k]) - NW'(r_p[2*k+1]);
            end
        end
    end

    // Stage 4: sign and magnitude, degenerate test.
    logic [MW-1:0] r_mag [3];
    logic [2:0]    r_neg4;
    logic          r_deg4;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_neg4[k] <= r_n[k][NW-1];
                r_mag[k]  <= r_n[k][NW-1] ? MW'(-r_n[k]) : MW'(r_n[k]);
            end
            r_deg4 <= (r_n[0] == '0) && (r_n[1] == '0) && (r_n[2] == '0);
        end
    end

    // Stage 5: shift count from the OR of the magnitudes.
    logic [MW-1:0] orm;
    logic [6:0]    n_k;
    assign orm = r_mag[0] | r_mag[1] | r_mag[2];
    always_comb begin
        n_k = '0;
        for (int b = 31; b < MW; b++) begin
            if (orm[b]) n_k = 7'(b - 30);
        end
    end
    logic [MW-1:0] r_mag5 [3];
    logic [6:0]    r_k5;
    logic [2:0]    r_neg5;
    logic          r_deg5;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mag5 <= r_mag;
            r_k5   <= n_k;
            r_neg5 <= r_neg4;
            r_deg5 <= r_deg4;
        end
    end

    // Stage 6: normalizing shift.
    logic [30:0] r_m6 [3];
    logic [2:0]  r_neg6;
    logic        r_deg6;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_m6[k] <= 31'(r_mag5[k] >> r_k5);
            end
            r_neg6 <= r_neg5;
            r_deg6 <= r_deg5;
        end
    end

    // Stage 7: squares.
    logic [61:0] r_sq [3];
    logic [30:0] r_m7 [3];
    logic [2:0]  r_neg7;
    logic        r_deg7;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= 62'(r_m6[k]) * 62'(r_m6[k]);
            end
            r_m7   <= r_m6;
            r_neg7 <= r_neg6;
            r_deg7 <= r_deg6;
        end
    end

    // Stage 8: sum of squares.
    logic [63:0] r_s8;
    logic [30:0] r_m8 [3];
    logic [2:0]  r_neg8;
    logic        r_deg8;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s8   <= 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]);
            r_m8   <= r_m7;
            r_neg8 <= r_neg7;
            r_deg8 <= r_deg7;
        end
    end

    // Square root: restoring, two radicand bits in and one result bit
    // out per stage.
    logic [63:0] r_sr_s  [NSQ];
    logic [31:0] r_sr_r  [NSQ];
    logic [31:0] r_sr_rm [NSQ];
    logic [30:0] r_sr_m  [NSQ][3];
    logic [2:0]  r_sr_ng [NSQ];
    logic        r_sr_dg [NSQ];
    for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
        logic [63:0] in_s;
        logic [31:0] in_r;
        logic [31:0] in_rm;
        logic [30:0] in_m [3];
        logic [2:0]  in_ng;
        logic        in_dg;
        logic [33:0] n_rm;
        logic [34:0] n_t;
        if (g == 0) begin : g_in
            assign in_s  = r_s8;
            assign in_r  = '0;
            assign in_rm = '0;
            assign in_m  = r_m8;
            assign in_ng = r_neg8;
            assign in_dg = r_deg8;
        end else begin : g_in
            assign in_s  = r_sr_s[g-1];
            assign in_r  = r_sr_r[g-1];
            assign in_rm = r_sr_rm[g-1];
            assign in_m  = r_sr_m[g-1];
            assign in_ng = r_sr_ng[g-1];
            assign in_dg = r_sr_dg[g-1];
        end
        assign n_rm = {in_rm, in_s[63:62]};
        assign n_t  = {1'b0, n_rm} - {1'b0, in_r, 2'b01};
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sr_s[g]  <= {in_s[61:0], 2'b00};
                r_sr_rm[g] <= n_t[34] ? n_rm[31:0] : n_t[31:0];
                r_sr_r[g]  <= {in_r[30:0], ~n_t[34]};
                r_sr_m[g]  <= in_m;
                r_sr_ng[g] <= in_ng;
                r_sr_dg[g] <= in_dg;
            end
        end
    end

    // Dividend and divisor setup.
    localparam int SQS = NSQ - 1;
    logic [31:0]  len;
    logic [QW-1:0] r_num [3];
    logic [31:0]  r_den;
    logic [2:0]   r_ng9;
    logic         r_dg9;
    assign len = (r_sr_r[SQS] == '0) ? 32'd1 : r_sr_r[SQS];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_num[k] <= (QW'(r_sr_m[SQS][k]) << NORMAL_FRAC_BITS) + QW'(len >> 1);
            end
            r_den <= len;
            r_ng9 <= r_sr_ng[SQS];
            r_dg9 <= r_sr_dg[SQS];
        end
    end

    // Three dividers in parallel; side bits delayed alongside.
    logic [QW-1:0] quo [3];
    for (genvar g = 0; g < 3; g++) begin : g_div
        tun_divider #(.NumWidth(QW), .DenWidth(32)) u_div (
            .i_clk(i_clk), .i_en(en),
            .i_num(r_num[g]), .i_den(r_den), .o_quo(quo[g]));
    end
    logic [2:0] r_ngd [QW];
    logic       r_dgd [QW];
    for (genvar g = 0; g < QW; g++) begin : g_side
        logic [2:0] in_ng;
        logic       in_dg;
        if (g == 0) begin : g_in
            assign in_ng = r_ng9;
            assign in_dg = r_dg9;
        end else begin : g_in
            assign in_ng = r_ngd[g-1];
            assign in_dg = r_dgd[g-1];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ngd[g] <= in_ng;
                r_dgd[g] <= in_dg;
            end
        end
    end

    // Output stage: sign, clamp, zero for degenerate, pack.
    logic [OutWidth-1:0] n_o [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [QW:0] sq;
            sq = r_ngd[QW-1][k] ? -{1'b0, quo[k]} : {1'b0, quo[k]};
            if (r_dgd[QW-1]) n_o[k] = '0;
            else if (!r_ngd[QW-1][k] && quo[k] > QW'(32767)) n_o[k] = 16'h7fff;
            else if (r_ngd[QW-1][k] && quo[k] > QW'(32768)) n_o[k] = 16'h8000;
            else n_o[k] = sq[OutWidth-1:0];
        end
    end
    logic [47:0] r_out;
    logic        r_deg_o;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out   <= {n_o[2], n_o[1], n_o[0]};
            r_deg_o <= r_dgd[QW-1];
        end
    end
    assign m_axis_tdata = r_out;
    assign m_axis_tuser = r_deg_o;
endmodule

@@ rtl/core/tun_checker.sv @@
// Port-level checker for the triangle unit normal block, with its bind.
module tun_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("degenerate word with nonzero normal");
endmodule

bind triangle_unit_normal_core tun_checker u_tun_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser));

@@ tb/triangle_unit_normal_core_tb.sv @@
// Testbench for the triangle unit normal core: randomized streaming check against a model.
`timescale 1ns / 100ps

module triangle_unit_normal_core_tb;
    import tun_pkg::*;

    localparam int InBits    = ((9 * CoordWidth + 7) / 8) * 8;
    localparam int DrainWait = 200;

    typedef struct packed {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        degen;
    } normal_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [InBits-1:0] s_axis_tdata = '0;     // ax, ay, az, bx, by_coord, bz, cx, cy, cz
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [47:0]       m_axis_tdata;          // normal_x, normal_y, normal_z
    logic              m_axis_tuser;          // degenerate

    logic [InBits-1:0] tri_queue[$];
    normal_t           normal_queue[$];
    int                err_count = 0;
    bit                no_idle = 1'b0;
    int                hold_off = 0;
    bit                stim_done = 1'b0;
    bit                pause_send = 1'b0;

    triangle_unit_normal_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Unit normal of one packed triangle word
    function automatic normal_t face_normal(logic [InBits-1:0] w);
        logic signed [CoordWidth-1:0] c[9];
        logic signed [47:0]           u[3], v[3];
        logic signed [127:0]          n[3];
        logic [127:0]                 mag[3];
        logic [63:0]                  m[3], s, len, q;
        logic signed [64:0]           sv;
        normal_t                      r;
        for (int i = 0; i < 9; i++) c[i] = w[i*CoordWidth +: CoordWidth];
        for (int i = 0; i < 3; i++) begin
            u[i] = 48'(c[3+i]) - 48'(c[i]);
            v[i] = 48'(c[6+i]) - 48'(c[i]);
        end
        n[0] = 128'(u[1]) * 128'(v[2]) - 128'(u[2]) * 128'(v[1]);
        n[1] = 128'(u[2]) * 128'(v[0]) - 128'(u[0]) * 128'(v[2]);
        n[2] = 128'(u[0]) * 128'(v[1]) - 128'(u[1]) * 128'(v[0]);
        r = '0;
        if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
            r.degen = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++) mag[i] = n[i] < 0 ? -n[i] : n[i];
        // common truncating shift until all magnitudes fit in 31 bits
        while (mag[0] >= 2**31 || mag[1] >= 2**31 || mag[2] >= 2**31)
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        for (int i = 0; i < 3; i++) m[i] = mag[i][63:0];
        s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = 0;
        for (int b = 31; b >= 0; b--)
            if ((len | (64'd1 << b)) * (len | (64'd1 << b)) <= s) len |= 64'd1 << b;
        if (len == 0) len = 1;
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << NormalFracBits) + (len >> 1)) / len;
            sv = n[i] < 0 ? -$signed({1'b0, q}) : $signed({1'b0, q});
            if (sv > 32767) sv = 32767;
            if (sv < -32768) sv = -32768;
            if (i == 0) r.nx = sv[15:0];
            else if (i == 1) r.ny = sv[15:0];
            else r.nz = sv[15:0];
        end
        return r;
    endfunction

    function automatic logic [InBits-1:0] pack_tri(int c[9]);
        logic [InBits-1:0] w = '0;
        for (int i = 0; i < 9; i++) w[i*CoordWidth +: CoordWidth] = c[i][CoordWidth-1:0];
        return w;
    endfunction

    function automatic int rand_coord(int mode);
        case (mode)
            0: return $urandom_range(0, 255) - 128;
            1: return $urandom_range(0, 8191) - 4096;
            2: return ($urandom_range(0, 1) != 0) ? 8388607 - $urandom_range(0, 3)
                                                  : -8388608 + $urandom_range(0, 3);
            default: return $signed($urandom()) >>> 8;
        endcase
    endfunction

    // Stimulus
    initial begin
        int c[9];
        int lo = -8388608, hi = 8388607;
        int mode;
        c = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0};  tri_queue.push_back(pack_tri(c));
        c = '{0, 0, 0, 0, 4096, 0, 0, 0, 4096};  tri_queue.push_back(pack_tri(c));
        c = '{0, 0, 0, 0, 0, 4096, 4096, 0, 0};  tri_queue.push_back(pack_tri(c));
        c = '{5, 5, 5, 5, 5, 5, 5, 5, 5};        tri_queue.push_back(pack_tri(c));
        c = '{0, 0, 0, 1, 1, 1, 2, 2, 2};        tri_queue.push_back(pack_tri(c));
        c = '{lo, lo, lo, hi, lo, lo, lo, hi, lo}; tri_queue.push_back(pack_tri(c));
        c = '{hi, hi, hi, lo, hi, hi, hi, lo, hi}; tri_queue.push_back(pack_tri(c));
        c = '{lo, hi, lo, hi, lo, hi, lo, lo, hi}; tri_queue.push_back(pack_tri(c));
        c = '{hi, lo, hi, lo, hi, lo, hi, hi, lo}; tri_queue.push_back(pack_tri(c));
        c = '{-1, -1, -1, -1, -1, -1, -1, -1, -1}; tri_queue.push_back(pack_tri(c));
        c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};        tri_queue.push_back(pack_tri(c));
        c = '{0, 0, 0, 3, 1, 0, 1, 3, 0};        tri_queue.push_back(pack_tri(c));
        c = '{lo, lo, lo, hi, hi, hi, hi, lo, 0}; tri_queue.push_back(pack_tri(c));
        c = '{0, 0, 0, -4096, 0, 0, 0, -4096, 0}; tri_queue.push_back(pack_tri(c));
        c = '{hi, hi, hi, hi, hi, hi, lo, lo, lo}; tri_queue.push_back(pack_tri(c));
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < 900; k++) begin
            if (k == 300) begin
                // drain fully before continuing
                wait (tri_queue.size() == 0 && !s_axis_tvalid);
                pause_send = 1'b1;
                wait (normal_queue.size() == 0);
                pause_send = 1'b0;
            end
            if (k == 500) hold_off = 300;
            no_idle = (k >= 600 && k < 750);
            mode = $urandom_range(0, 3);
            for (int i = 0; i < 9; i++) c[i] = rand_coord(mode);
            if ($urandom_range(0, 19) == 0) begin
                // collinear or repeated vertex
                c[6] = c[3]; c[7] = c[4]; c[8] = c[5];
            end
            tri_queue.push_back(pack_tri(c));
            if (tri_queue.size() > 16) wait (tri_queue.size() <= 16);
        end
        wait (tri_queue.size() == 0 && !s_axis_tvalid);
        stim_done = 1'b1;
    end

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) normal_queue.push_back(face_normal(s_axis_tdata));
            if (tri_queue.size() > 0 && !pause_send
                    && (no_idle || $urandom_range(0, 99) >= 23)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= tri_queue.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor and receiver stalls
    always @(posedge i_clk) begin
        normal_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (normal_queue.size() == 0) begin
                $error("unexpected normal word %h/%b", m_axis_tdata, m_axis_tuser);
                err_count++;
            end else begin
                want = normal_queue.pop_front();
                if (m_axis_tdata[15:0] !== want.nx) begin
                    $error("normal_x exp %h got %h", want.nx, m_axis_tdata[15:0]);
                    err_count++;
                end
                if (m_axis_tdata[31:16] !== want.ny) begin
                    $error("normal_y exp %h got %h", want.ny, m_axis_tdata[31:16]);
                    err_count++;
                end
                if (m_axis_tdata[47:32] !== want.nz) begin
                    $error("normal_z exp %h got %h", want.nz, m_axis_tdata[47:32]);
                    err_count++;
                end
                if (m_axis_tuser !== want.degen) begin
                    $error("degenerate exp %b got %b", want.degen, m_axis_tuser);
                    err_count++;
                end
            end
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= no_idle || $urandom_range(0, 99) >= 23;
        end
    end

    // End of run
    initial begin
        wait (stim_done);
        wait (normal_queue.size() == 0);
        repeat (DrainWait) @(posedge i_clk);
        if (err_count == 0 && normal_queue.size() == 0)
            $display("triangle_unit_normal_core_tb: done, clean");
        else
            $display("triangle_unit_normal_core_tb: done, errors");
        $finish;
    end

    initial begin
        #2000000;
        $display("triangle_unit_normal_core_tb: done, errors");
        $finish;
    end
endmodule

@@ files.f @@
rtl/core/tun_pkg.sv
rtl/core/tun_divider.sv
rtl/core/triangle_unit_normal_core.sv
rtl/core/tun_checker.sv
tb/triangle_unit_normal_core_tb.sv
